// File: hdl/pfp_pkg.sv
// ============================================================================
// pfp_pkg
// Shared types, codes and widths for the page frame pool with block hash.
// ============================================================================
`default_nettype none

package pfp_pkg;

    // default sizes
    localparam int FRAMES_DEF       = 1024;
    localparam int HASH_BUCKETS_DEF = 256;
    localparam int MAX_RUN_DEF      = 64;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int FRAME_W  = 10;
    localparam int COUNT_W  = 7;
    localparam int DEV_W    = 16;
    localparam int BLK_W    = 24;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 11;
    localparam int UC_W     = 8;
    localparam int FIRST_W  = 10;
    localparam int END_W    = 11;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
    localparam logic [OP_W-1:0] OP_GIVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd5;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd6;
    localparam logic [OP_W-1:0] OP_INIT    = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOFREE   = 3'd4;

    // register select (paddr bit 2)
    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_END   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block_number;
        logic               disk_backed;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_out;
        logic [STATUS_W-1:0] status;
        logic [FREE_W-1:0]   free_pages;
        logic                last;
    } t_res;

    // request to the remainder unit
    typedef struct packed {
        logic             start;
        logic [BLK_W-1:0] value;
    } t_mod_req;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_EMIT, S_MOD_WAIT, S_BKT_DAT, S_WALK_CHK, S_WALK_RD,
        S_AL_CHK, S_AL_RD, S_AL_OUT, S_REL_RD, S_REL_P1, S_REL_P2,
        S_INS_RD, S_INS_LINK, S_INS_FIN, S_REM_RD, S_UNL_DONE, S_INIT
    } t_state;

    typedef enum logic [1:0] {
        W_FIND, W_UNLINK, W_TAIL
    } t_walk;

endpackage

`default_nettype wire

// File: hdl/pfp_if.sv
// ============================================================================
// pfp_in_if / pfp_out_if
// Valid/ready channels for operation requests and result items.
// ============================================================================
`default_nettype none

interface pfp_in_if;
    import pfp_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic               disk_backed;

    modport source (output valid, op, frame, count, device, block_number, disk_backed,
                    input ready);
    modport sink (input valid, op, frame, count, device, block_number, disk_backed,
                  output ready);
endinterface

interface pfp_out_if;
    import pfp_pkg::*;
    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  frame_out;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_pages;
    logic                last;

    modport source (output valid, frame_out, status, free_pages, last, input ready);
    modport sink (input valid, frame_out, status, free_pages, last, output ready);
endinterface

`default_nettype wire

// File: hdl/pfp_mod.sv
// ============================================================================
// pfp_mod
// Shared remainder unit: block number modulo the bucket count by reciprocal
// multiplication, quotient in one step and remainder in the next.
// ============================================================================
`default_nettype none

module pfp_mod import pfp_pkg::*; #(
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  t_mod_req                          i_req,
    output logic                              o_done,
    output logic [$clog2(HASH_BUCKETS)-1:0]   o_rem
);
    localparam int BW    = $clog2(HASH_BUCKETS);
    // q = (v * RCP) >> SH equals v / HASH_BUCKETS for every BLK_W-bit v,
    // since RCP * HASH_BUCKETS exceeds 2**SH by at most 2**BW
    localparam int SH    = BLK_W + BW;
    localparam int RCP_W = BLK_W + 2;
    localparam int PW    = BLK_W + RCP_W;
    localparam logic [63:0]      RCP_L = ((64'd1 << SH) / 64'(HASH_BUCKETS)) + 64'd1;
    localparam logic [RCP_W-1:0] RCP   = RCP_W'(RCP_L);
    localparam logic [BLK_W-1:0] HB_B  = BLK_W'(HASH_BUCKETS);

    logic             r_busy, n_busy;
    logic             r_stg, n_stg;
    logic             r_done, n_done;
    logic [BLK_W-1:0] r_val, n_val;
    logic [BLK_W-1:0] r_quo, n_quo;
    logic [BW-1:0]    r_rem, n_rem;
    logic [PW-1:0]    w_prod;
    logic [BLK_W-1:0] w_back;

    // quotient step, then remainder step
    always_comb begin
        w_prod = PW'(r_val) * PW'(RCP);
        w_back = r_quo * HB_B;
        n_busy = r_busy;
        n_stg  = r_stg;
        n_done = 1'b0;
        n_val  = r_val;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_stg  = 1'b0;
            n_val  = i_req.value;
        end else if (r_busy) begin
            if (!r_stg) begin
                n_quo = BLK_W'(w_prod >> SH);
                n_stg = 1'b1;
            end else begin
                // true remainder fits in BW bits, so the low bits suffice
                n_rem  = BW'(r_val - w_back);
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_stg  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_stg  <= n_stg;
            r_done <= n_done;
        end
        r_val <= n_val;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: hdl/pfp_engine.sv
// ============================================================================
// pfp_engine
// Sequencer with the frame, link and hash memories; walks queues and chains
// one memory access per step.
// ============================================================================
`default_nettype none

module pfp_engine import pfp_pkg::*; #(
    parameter int FRAMES       = FRAMES_DEF,
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF,
    parameter int MAX_RUN      = MAX_RUN_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_ready,
    input  t_req                i_req,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output t_res                o_res,
    input  wire [FIRST_W-1:0]   i_first,
    input  wire [END_W-1:0]     i_end
);
    localparam int FW  = $clog2(FRAMES);
    localparam int AW  = FW + 1;
    localparam int BW  = $clog2(HASH_BUCKETS);
    localparam int FCW = $clog2(FRAMES + 1);
    localparam int XW  = (AW > FREE_W) ? AW : FREE_W;
    localparam int CLR = (FRAMES > HASH_BUCKETS) ? FRAMES : HASH_BUCKETS;
    localparam int CLW = $clog2(CLR);
    localparam logic [AW-1:0] NIL      = AW'(FRAMES);
    localparam logic [XW-1:0] FRAMES_X = XW'(FRAMES);

    // memories
    logic [AW-1:0]    m_qn [FRAMES];
    logic [AW-1:0]    m_qp [FRAMES];
    logic [AW-1:0]    m_cn [FRAMES];
    logic [DEV_W-1:0] m_dev[FRAMES];
    logic [BLK_W-1:0] m_blk[FRAMES];
    logic [UC_W-1:0]  m_uc [FRAMES];
    logic             m_hm [FRAMES];
    logic             m_qd [FRAMES];
    logic [AW-1:0]    m_bf [HASH_BUCKETS];

    logic          qn_we, qp_we, cn_we, kv_we, uc_we, hm_we, qd_we, bf_we;
    logic [FW-1:0] qn_wa, qp_wa, cn_wa, kv_wa, uc_wa, hm_wa, qd_wa;
    logic [BW-1:0] bf_wa;
    logic [AW-1:0] qn_wd, qp_wd, cn_wd, bf_wd;
    logic [UC_W-1:0] uc_wd;
    logic          hm_wd, qd_wd;
    logic [FW-1:0] ra;
    logic [BW-1:0] bra;

    logic [AW-1:0]    qn_rd, cn_rd, bf_rd;
    logic [DEV_W-1:0] dev_rd;
    logic [BLK_W-1:0] blk_rd;
    logic [UC_W-1:0]  uc_rd;
    logic             hm_rd, qd_rd;

    // remainder unit
    t_mod_req      mod_req;
    logic          mod_done;
    logic [BW-1:0] mod_rem;

    pfp_mod #(.HASH_BUCKETS(HASH_BUCKETS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // sequencer registers
    t_state r_state, n_state, r_ret, n_ret;
    t_walk  r_wmode, n_wmode;
    logic [OP_W-1:0]    r_op, n_op;
    logic [FW-1:0]      r_fr, n_fr;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [DEV_W-1:0]   r_dev, n_dev;
    logic [BLK_W-1:0]   r_blk, n_blk;
    logic               r_tq, n_tq;
    logic [AW-1:0]      r_head, n_head, r_tail, n_tail;
    logic [FCW-1:0]     r_free, n_free;
    logic [AW-1:0]      r_cur, n_cur, r_prev, n_prev, r_steps, n_steps, r_first, n_first;
    logic [BW-1:0]      r_bkt, n_bkt;
    logic               r_found, n_found;
    logic [CLW-1:0]     r_idx, n_idx;
    logic [XW-1:0]      r_lo, n_lo, r_hi, n_hi;
    logic [FW-1:0]      r_rfr, n_rfr;
    logic [STATUS_W-1:0] r_rst, n_rst;
    logic               r_rlast, n_rlast;

    logic [XW-1:0] fr_x, lo_x, end_x, hi_x, sum_x, i_x;
    logic          w_hit, w_miss;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;    n_wmode = r_wmode;
        n_op    = r_op;     n_fr  = r_fr;     n_left  = r_left;
        n_dev   = r_dev;    n_blk = r_blk;    n_tq    = r_tq;
        n_head  = r_head;   n_tail = r_tail;  n_free  = r_free;
        n_cur   = r_cur;    n_prev = r_prev;  n_steps = r_steps;
        n_first = r_first;  n_bkt = r_bkt;    n_found = r_found;
        n_idx   = r_idx;    n_lo  = r_lo;     n_hi    = r_hi;
        n_rfr   = r_rfr;    n_rst = r_rst;    n_rlast = r_rlast;
        qn_we = 1'b0; qp_we = 1'b0; cn_we = 1'b0; kv_we = 1'b0;
        uc_we = 1'b0; hm_we = 1'b0; qd_we = 1'b0; bf_we = 1'b0;
        qn_wa = '0; qp_wa = '0; cn_wa = '0; kv_wa = '0;
        uc_wa = '0; hm_wa = '0; qd_wa = '0; bf_wa = '0;
        qn_wd = '0; qp_wd = '0; cn_wd = '0; bf_wd = '0;
        uc_wd = '0; hm_wd = 1'b0; qd_wd = 1'b0;
        ra  = '0;
        bra = r_bkt;
        mod_req = '0;
        w_hit  = 1'b0;
        w_miss = 1'b0;
        fr_x  = XW'(i_req.frame);
        lo_x  = XW'(i_first);
        end_x = XW'(i_end);
        hi_x  = (end_x > FRAMES_X) ? FRAMES_X : end_x;
        sum_x = XW'(r_free) + XW'(i_req.count);
        i_x   = XW'(r_idx);

        case (r_state)
            // reset sweep over counts, marks and buckets
            S_CLEAR: begin
                if (int'(r_idx) < FRAMES) begin
                    uc_we = 1'b1; uc_wa = r_idx[FW-1:0];
                    hm_we = 1'b1; hm_wa = r_idx[FW-1:0];
                    qd_we = 1'b1; qd_wa = r_idx[FW-1:0];
                end
                if (int'(r_idx) < HASH_BUCKETS) begin
                    bf_we = 1'b1; bf_wa = r_idx[BW-1:0]; bf_wd = NIL;
                end
                n_idx = r_idx + 1'b1;
                if (int'(r_idx) == CLR - 1) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                ra = fr_x[FW-1:0];
                if (i_req_valid) begin
                    n_op  = i_req.op;
                    n_fr  = fr_x[FW-1:0];
                    n_dev = i_req.device;
                    n_blk = i_req.block_number;
                    n_tq  = i_req.disk_backed;
                    n_rfr = '0;
                    n_rst = STAT_OK;
                    n_rlast = 1'b1;
                    n_ret = S_IDLE;
                    n_state = S_EMIT;
                    case (i_req.op)
                        OP_RESERVE: begin
                            if (XW'(r_free) >= XW'(i_req.count)) begin
                                n_free = r_free - FCW'(i_req.count);
                            end else begin
                                n_rst = STAT_NOFREE;
                            end
                        end
                        OP_GIVE: begin
                            n_free = (sum_x > FRAMES_X) ? FCW'(FRAMES) : FCW'(sum_x);
                        end
                        OP_ALLOC: begin
                            if (i_req.count != '0) begin
                                n_left = (int'(i_req.count) > MAX_RUN) ?
                                         COUNT_W'(MAX_RUN) : i_req.count;
                                n_state = S_AL_CHK;
                            end
                        end
                        OP_RELEASE, OP_INSERT, OP_REMOVE: begin
                            if (fr_x >= FRAMES_X) begin
                                n_rst = STAT_NOTFOUND;
                            end else if (i_req.op == OP_RELEASE) begin
                                n_state = S_REL_RD;
                            end else if (i_req.op == OP_INSERT) begin
                                n_state = S_INS_RD;
                            end else begin
                                n_state = S_REM_RD;
                            end
                        end
                        OP_FIND: begin
                            mod_req.start = 1'b1;
                            mod_req.value = i_req.block_number;
                            n_wmode = W_FIND;
                            n_state = S_MOD_WAIT;
                        end
                        default: begin
                            // init: queue rebuilt in order by a sweep
                            n_lo = lo_x;
                            n_hi = hi_x;
                            n_idx = '0;
                            if (lo_x < hi_x) begin
                                n_head = AW'(lo_x);
                                n_tail = AW'(hi_x - 1'b1);
                                n_free = FCW'(hi_x - lo_x);
                            end else begin
                                n_head = NIL;
                                n_tail = NIL;
                                n_free = '0;
                            end
                            n_state = S_INIT;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = r_ret;
                end
            end

            S_MOD_WAIT: begin
                if (mod_done) begin
                    n_bkt = mod_rem;
                    bra = mod_rem;
                    n_state = S_BKT_DAT;
                end
            end

            S_BKT_DAT: begin
                n_cur   = bf_rd;
                n_first = bf_rd;
                n_prev  = NIL;
                n_steps = '0;
                n_state = S_WALK_CHK;
            end

            // chain walk: bound check, then read the entry
            S_WALK_CHK: begin
                if (r_cur >= NIL) begin
                    w_miss = 1'b1;
                end else if (r_steps == NIL) begin
                    if (r_wmode == W_TAIL) begin
                        w_hit = 1'b1;
                    end else begin
                        w_miss = 1'b1;
                    end
                end else begin
                    ra = r_cur[FW-1:0];
                    n_state = S_WALK_RD;
                end
            end

            S_WALK_RD: begin
                case (r_wmode)
                    W_FIND:   w_hit = (blk_rd == r_blk) && (dev_rd == r_dev);
                    W_UNLINK: w_hit = (r_cur == {1'b0, r_fr});
                    default:  w_hit = (cn_rd >= NIL);
                endcase
                if (w_hit && r_wmode == W_UNLINK) begin
                    if (r_prev == NIL) begin
                        bf_we = 1'b1; bf_wa = r_bkt; bf_wd = cn_rd;
                    end else begin
                        cn_we = 1'b1; cn_wa = r_prev[FW-1:0]; cn_wd = cn_rd;
                    end
                end
                if (!w_hit) begin
                    n_prev  = r_cur;
                    n_cur   = cn_rd;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK_CHK;
                end
            end

            // alloc: pop the head, one frame per pass
            S_AL_CHK: begin
                if (r_head >= NIL) begin
                    n_rfr = '0; n_rst = STAT_EMPTY; n_rlast = 1'b1;
                    n_ret = S_IDLE; n_state = S_EMIT;
                end else begin
                    ra = r_head[FW-1:0];
                    n_state = S_AL_RD;
                end
            end

            S_AL_RD: begin
                n_fr = r_head[FW-1:0];
                if (qn_rd >= NIL) begin
                    n_head = NIL;
                    n_tail = NIL;
                end else begin
                    n_head = qn_rd;
                    qp_we = 1'b1; qp_wa = qn_rd[FW-1:0]; qp_wd = NIL;
                end
                qd_we = 1'b1; qd_wa = r_head[FW-1:0]; qd_wd = 1'b0;
                uc_we = 1'b1; uc_wa = r_head[FW-1:0]; uc_wd = UC_W'(1);
                if (hm_rd) begin
                    mod_req.start = 1'b1;
                    mod_req.value = blk_rd;
                    n_wmode = W_UNLINK;
                    n_state = S_MOD_WAIT;
                end else begin
                    n_state = S_AL_OUT;
                end
            end

            S_AL_OUT: begin
                n_rfr = r_fr;
                n_rst = STAT_OK;
                n_rlast = (r_left == COUNT_W'(1));
                n_ret = (r_left == COUNT_W'(1)) ? S_IDLE : S_AL_CHK;
                n_left = r_left - 1'b1;
                n_state = S_EMIT;
            end

            // release: drop the use count, queue the frame at zero
            S_REL_RD: begin
                n_ret = S_IDLE;
                n_state = S_EMIT;
                if (uc_rd == '0) begin
                    n_rst = STAT_NOTFOUND;
                end else begin
                    uc_we = 1'b1; uc_wa = r_fr; uc_wd = uc_rd - UC_W'(1);
                    if (uc_rd == UC_W'(1) && !qd_rd) begin
                        n_state = S_REL_P1;
                    end
                end
            end

            S_REL_P1: begin
                qn_we = 1'b1; qn_wa = r_fr;
                qp_we = 1'b1; qp_wa = r_fr;
                if (r_tq) begin
                    qn_wd = NIL;    qp_wd = r_tail;
                end else begin
                    qn_wd = r_head; qp_wd = NIL;
                end
                qd_we = 1'b1; qd_wa = r_fr; qd_wd = 1'b1;
                n_state = S_REL_P2;
            end

            S_REL_P2: begin
                if (r_tq) begin
                    if (r_tail == NIL) begin
                        n_head = {1'b0, r_fr};
                    end else begin
                        qn_we = 1'b1; qn_wa = r_tail[FW-1:0]; qn_wd = {1'b0, r_fr};
                    end
                    n_tail = {1'b0, r_fr};
                end else begin
                    if (r_head == NIL) begin
                        n_tail = {1'b0, r_fr};
                    end else begin
                        qp_we = 1'b1; qp_wa = r_head[FW-1:0]; qp_wd = {1'b0, r_fr};
                    end
                    n_head = {1'b0, r_fr};
                end
                if (int'(r_free) < FRAMES) begin
                    n_free = r_free + 1'b1;
                end
                n_state = S_EMIT;
            end

            // insert: reject hashed frames, then look for the key
            S_INS_RD: begin
                if (hm_rd) begin
                    n_rst = STAT_DUP;
                    n_state = S_EMIT;
                end else begin
                    mod_req.start = 1'b1;
                    mod_req.value = r_blk;
                    n_wmode = W_FIND;
                    n_state = S_MOD_WAIT;
                end
            end

            S_INS_LINK: begin
                cn_we = 1'b1; cn_wa = r_fr; cn_wd = NIL;
                if (r_first >= NIL) begin
                    bf_we = 1'b1; bf_wa = r_bkt; bf_wd = {1'b0, r_fr};
                    n_wmode = W_FIND;
                    n_state = S_INS_FIN;
                end else begin
                    n_wmode = W_TAIL;
                    n_cur   = r_first;
                    n_steps = '0;
                    n_state = S_WALK_CHK;
                end
            end

            S_INS_FIN: begin
                kv_we = 1'b1; kv_wa = r_fr;
                hm_we = 1'b1; hm_wa = r_fr; hm_wd = 1'b1;
                if (r_wmode == W_TAIL) begin
                    cn_we = 1'b1; cn_wa = r_cur[FW-1:0]; cn_wd = {1'b0, r_fr};
                end
                n_rst = STAT_OK;
                n_state = S_EMIT;
            end

            S_REM_RD: begin
                if (!hm_rd) begin
                    n_rst = STAT_NOTFOUND;
                    n_state = S_EMIT;
                end else begin
                    mod_req.start = 1'b1;
                    mod_req.value = blk_rd;
                    n_wmode = W_UNLINK;
                    n_state = S_MOD_WAIT;
                end
            end

            S_UNL_DONE: begin
                hm_we = 1'b1; hm_wa = r_fr; hm_wd = 1'b0;
                cn_we = 1'b1; cn_wa = r_fr; cn_wd = NIL;
                if (r_op == OP_ALLOC) begin
                    n_state = S_AL_OUT;
                end else begin
                    n_rst = r_found ? STAT_OK : STAT_NOTFOUND;
                    n_state = S_EMIT;
                end
            end

            // init sweep: frames in range linked in order, others unqueued
            S_INIT: begin
                qd_we = 1'b1; qd_wa = r_idx[FW-1:0];
                if (i_x >= r_lo && i_x < r_hi) begin
                    qd_wd = 1'b1;
                    qn_we = 1'b1; qn_wa = r_idx[FW-1:0];
                    qn_wd = (i_x + 1'b1 < r_hi) ? AW'(i_x + 1'b1) : NIL;
                    qp_we = 1'b1; qp_wa = r_idx[FW-1:0];
                    qp_wd = (i_x == r_lo) ? NIL : AW'(i_x - 1'b1);
                    uc_we = 1'b1; uc_wa = r_idx[FW-1:0]; uc_wd = '0;
                end
                n_idx = r_idx + 1'b1;
                if (int'(r_idx) == FRAMES - 1) begin
                    n_rst = STAT_OK;
                    n_state = S_EMIT;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of a chain walk
        if (w_hit || w_miss) begin
            case (r_wmode)
                W_FIND: begin
                    if (r_op == OP_FIND) begin
                        n_rfr = w_hit ? r_cur[FW-1:0] : '0;
                        n_rst = w_hit ? STAT_OK : STAT_NOTFOUND;
                        n_state = S_EMIT;
                    end else if (w_hit) begin
                        n_rst = STAT_DUP;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_INS_LINK;
                    end
                end
                W_UNLINK: begin
                    n_found = w_hit;
                    n_state = S_UNL_DONE;
                end
                default: begin
                    n_state = S_INS_FIN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_free  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_idx   <= n_idx;
        end
        r_wmode <= n_wmode;  r_op  <= n_op;   r_fr    <= n_fr;
        r_left  <= n_left;   r_dev <= n_dev;  r_blk   <= n_blk;
        r_tq    <= n_tq;     r_cur <= n_cur;  r_prev  <= n_prev;
        r_steps <= n_steps;  r_first <= n_first; r_bkt <= n_bkt;
        r_found <= n_found;  r_lo  <= n_lo;   r_hi    <= n_hi;
        r_rfr   <= n_rfr;    r_rst <= n_rst;  r_rlast <= n_rlast;
    end

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (qn_we) m_qn[qn_wa] <= qn_wd;
        if (qp_we) m_qp[qp_wa] <= qp_wd;
        if (cn_we) m_cn[cn_wa] <= cn_wd;
        if (kv_we) begin
            m_dev[kv_wa] <= r_dev;
            m_blk[kv_wa] <= r_blk;
        end
        if (uc_we) m_uc[uc_wa] <= uc_wd;
        if (hm_we) m_hm[hm_wa] <= hm_wd;
        if (qd_we) m_qd[qd_wa] <= qd_wd;
        if (bf_we) m_bf[bf_wa] <= bf_wd;
        qn_rd  <= m_qn[ra];
        cn_rd  <= m_cn[ra];
        dev_rd <= m_dev[ra];
        blk_rd <= m_blk[ra];
        uc_rd  <= m_uc[ra];
        hm_rd  <= m_hm[ra];
        qd_rd  <= m_qd[ra];
        bf_rd  <= m_bf[bra];
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res.frame_out  = FRAME_W'(XW'(r_rfr));
    assign o_res.status     = r_rst;
    assign o_res.free_pages = FREE_W'(XW'(r_free));
    assign o_res.last       = r_rlast;

endmodule

`default_nettype wire

// File: hdl/page_frame_pool_with_block_hash_core.sv
// Find, insert and remove walk the bucket chain; alloc pops one frame per pass and
//   unlinks a hashed frame from its bucket chain before returning it.
// Requests: one at a time; init sweeps all FRAMES frames; bucket index takes 2 steps.
// Reset: synchronous, active low; a clearing pass over max(FRAMES, HASH_BUCKETS)
//   entries follows, during which no request is taken.
// ============================================================================
// page_frame_pool_with_block_hash_core
// Top level: APB registers, request intake and output register.
// ============================================================================
`default_nettype none

module page_frame_pool_with_block_hash_core import pfp_pkg::*; #(
    parameter int FRAMES       = FRAMES_DEF,
    parameter int HASH_BUCKETS = HASH_BUCKETS_DEF,
    parameter int MAX_RUN      = MAX_RUN_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    pfp_in_if.sink             i_req,
    pfp_out_if.source          o_res,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [APB_AW-1:0]   paddr,
    input  wire [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);
    logic [FIRST_W-1:0] r_first;
    logic [END_W-1:0]   r_end;
    t_req   w_req;
    t_res   w_res;
    logic   w_res_valid, w_res_ready;
    logic   r_ov;
    t_res   r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_end   <= END_W'(1024);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_FIRST) begin
                r_first <= pwdata[FIRST_W-1:0];
            end else begin
                r_end <= pwdata[END_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_END) ? APB_DW'(r_end) : APB_DW'(r_first);

    assign w_req.op           = i_req.op;
    assign w_req.frame        = i_req.frame;
    assign w_req.count        = i_req.count;
    assign w_req.device       = i_req.device;
    assign w_req.block_number = i_req.block_number;
    assign w_req.disk_backed  = i_req.disk_backed;

    pfp_engine #(
        .FRAMES       (FRAMES),
        .HASH_BUCKETS (HASH_BUCKETS),
        .MAX_RUN      (MAX_RUN)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .i_first     (r_first),
        .i_end       (r_end)
    );

    // output register
    assign w_res_ready = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.frame_out  = r_out.frame_out;
    assign o_res.status     = r_out.status;
    assign o_res.free_pages = r_out.free_pages;
    assign o_res.last       = r_out.last;

endmodule

`default_nettype wire

// File: hdl/pfp_checker.sv
// ============================================================================
// pfp_checker
// Port-level checks on the pool core, bound to the top level.
// ============================================================================
`default_nettype none

module pfp_checker import pfp_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [STATUS_W-1:0] i_status,
    input wire [FREE_W-1:0]   i_free_pages
);
    // status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status <= STAT_NOFREE))
        else $error("undefined status code");

    // free count never exceeds the pool
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_free_pages) <= FRAMES))
        else $error("free count above pool size");

    // one request at a time: busy right after intake
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while busy");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_free_pages)))
        else $error("stalled result changed");

endmodule

bind page_frame_pool_with_block_hash_core pfp_checker #(.FRAMES(FRAMES)) u_pfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_free_pages (o_res.free_pages)
);

`default_nettype wire
